// ----- design/tce_pkg.sv -----
package tce_pkg;

    localparam int COLUMNS     = 80;
    localparam int ROWS        = 25;
    localparam int MAX_ARGS    = 4;
    localparam int CELLS       = COLUMNS * ROWS;
    localparam int QUEUE_DEPTH = 2;

    localparam int IDX_W  = 11;
    localparam int WORD_W = 16;
    localparam int ATTR_W = 8;
    localparam int CHR_W  = 8;
    localparam int ARG_W  = 16;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int LIN_W  = ADDR_W + 1;
    localparam int ROW_W  = $clog2(ROWS + 1);
    localparam int COL_W  = $clog2(COLUMNS + 1);
    localparam int ARGC_W = $clog2(MAX_ARGS + 2);
    localparam int ARGI_W = $clog2(MAX_ARGS);
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int ARG_MAX    = 65535;
    localparam int RECIP_SH   = 20;
    localparam int ROW_RECIP  = (1 << RECIP_SH) / ROWS + 1;
    localparam int COL_RECIP  = (1 << RECIP_SH) / COLUMNS + 1;
    localparam int SAT_ROW    = ARG_MAX % ROWS;
    localparam int SAT_COL    = ARG_MAX % COLUMNS;

    localparam logic [CHR_W-1:0] CH_ESC   = 8'h1B;
    localparam logic [CHR_W-1:0] CH_LBRK  = 8'h5B;
    localparam logic [CHR_W-1:0] CH_SEMI  = 8'h3B;
    localparam logic [CHR_W-1:0] CH_HOME  = 8'h48;
    localparam logic [CHR_W-1:0] CH_CLR   = 8'h4A;
    localparam logic [CHR_W-1:0] CH_ERASE = 8'h4B;
    localparam logic [CHR_W-1:0] CH_GOTO  = 8'h66;
    localparam logic [CHR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHR_W-1:0] CH_PR_LO = 8'h20;
    localparam logic [CHR_W-1:0] CH_PR_HI = 8'h7E;
    localparam logic [WORD_W-1:0] BLANK_CELL = 16'h0020;
    localparam logic [WORD_W-1:0] ATTR_MASK  = 16'hFF00;

    typedef enum logic [0:0] {
        OPC_PUT  = 1'b0,
        OPC_READ = 1'b1
    } opc_t;

    typedef enum logic [1:0] {
        M_NORMAL,
        M_ESCAPE,
        M_BRACKET
    } mode_t;

    typedef enum logic [2:0] {
        OP_READ,
        OP_RAW,
        OP_ESC_RAW,
        OP_HOME,
        OP_WIPE_ALL,
        OP_WIPE_LINE,
        OP_GOTO,
        OP_NOP
    } op_kind_t;

    typedef struct packed {
        op_kind_t            kind;
        logic [CHR_W-1:0]    chr;
        logic [ADDR_W-1:0]   idx;
        logic                idx_ok;
        logic [ROW_W-1:0]    row;
        logic [COL_W-1:0]    col;
    } op_t;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_READ,
        B_PUT,
        B_SCROLL,
        B_FILL,
        B_WIPE,
        B_EMIT
    } back_state_t;

    // residue by reciprocal multiply; exact for x below 2**RECIP_SH / divisor
    function automatic logic [ROW_W-1:0] mod_rows(input logic [11:0] x);
        logic [31:0] q;
        logic [31:0] r;
        q = (32'(x) * 32'(ROW_RECIP)) >> RECIP_SH;
        r = 32'(x) - q * 32'(ROWS);
        if (r >= 32'(ROWS))
        begin
            r = r - 32'(ROWS);
        end
        return r[ROW_W-1:0];
    endfunction

    function automatic logic [COL_W-1:0] mod_cols(input logic [11:0] x);
        logic [31:0] q;
        logic [31:0] r;
        q = (32'(x) * 32'(COL_RECIP)) >> RECIP_SH;
        r = 32'(x) - q * 32'(COLUMNS);
        if (r >= 32'(COLUMNS))
        begin
            r = r - 32'(COLUMNS);
        end
        return r[COL_W-1:0];
    endfunction

endpackage

// ----- design/text_console_escape_engine.sv -----
// Text console: an 80x25 screen of 16-bit cells (attribute high, character low)
// driven by a byte stream with ESC [ sequences (H, J, K, f).
// Command channel: drive start with opcode, char_byte and cell_index; the
// transaction is taken on a clock edge with start high and busy low.
// opcode 0 puts a byte, opcode 1 reads cell cell_index.
// Every transaction gives one result: done is high for exactly one cycle with
// cursor_position and cell_word; the receiver cannot stall it.
// Config channel: cfg_data is written to the text attribute when cfg_valid is
// high; cfg_ready is always high. Write only while the block is idle.
// A front parser classifies bytes into a two-entry queue; the back end owns the
// cursor and the screen RAM (one write and one read port) and runs commands.
// A read passes B_READ, then B_EMIT; H, f and bytes the parser only collects go
// to B_EMIT; a byte put to the screen (CR, LF, BS, TAB too) passes B_PUT; a
// dropped ESC is put in B_PUT before the byte after it. busy drops while the
// queue has room, so up to two transactions are taken ahead of the back end.
// Clearing (J) walks every cell; K walks one line. A byte that runs past the
// last cell scrolls.
// Reset: parser, cursor and attribute (10) reset at once; then the screen
// RAM is zeroed one cell a cycle, with busy held high.
module text_console_escape_engine
    import tce_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               opcode,
    input  logic [CHR_W-1:0]   char_byte,
    input  logic [IDX_W-1:0]   cell_index,
    output logic               done,
    output logic [IDX_W-1:0]   cursor_position,
    output logic [WORD_W-1:0]  cell_word,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [ATTR_W-1:0]  cfg_data
);

    logic [ATTR_W-1:0] attr_reg;
    logic              take;
    logic              push;
    op_t               push_op;
    op_t               head_op;
    logic              q_empty;
    logic              q_full;
    logic              pop;
    logic              clearing;

    assign cfg_ready = 1'b1;
    assign busy      = clearing || q_full;
    assign take      = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= ATTR_W'(10);
        end
        else if (cfg_valid && cfg_ready)
        begin
            attr_reg <= cfg_data;
        end
    end

    tce_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .opcode     (opcode),
        .char_byte  (char_byte),
        .cell_index (cell_index),
        .push       (push),
        .push_op    (push_op)
    );

    tce_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head_op (head_op),
        .empty   (q_empty),
        .full    (q_full)
    );

    tce_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .attr            (attr_reg),
        .head_op         (head_op),
        .empty           (q_empty),
        .pop             (pop),
        .clearing        (clearing),
        .done            (done),
        .cursor_position (cursor_position),
        .cell_word       (cell_word)
    );

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (32'(cursor_position) < 32'(CELLS)))
        else $error("cursor beyond screen");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("queue overflow");

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_empty)
        else $error("pop from empty queue");

endmodule

// ----- design/tce_ram.sv -----
module tce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/tce_queue.sv -----
module tce_queue
    import tce_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  push_op,
    input  logic pop,
    output op_t  head_op,
    output logic empty,
    output logic full
);

    op_t               slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next;
    logic [QPTR_W-1:0] rd_reg, rd_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = (wr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_next = (rd_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_op;
        end
    end

    assign head_op = slot_reg[rd_reg];
    assign empty   = (cnt_reg == '0);
    assign full    = (cnt_reg == QCNT_W'(QUEUE_DEPTH));

endmodule

// ----- design/tce_front.sv -----
module tce_front
    import tce_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic              opcode,
    input  logic [CHR_W-1:0]  char_byte,
    input  logic [IDX_W-1:0]  cell_index,
    output logic              push,
    output op_t               push_op
);

    mode_t              mode_reg, mode_next;
    logic [ARGC_W-1:0]  argc_reg, argc_next;
    logic [ARG_W-1:0]   arg_reg [MAX_ARGS];
    logic [ARG_W-1:0]   arg_next [MAX_ARGS];
    logic [ROW_W-1:0]   rres_reg, rres_next;
    logic [COL_W-1:0]   cres_reg, cres_next;

    logic [ARGC_W-1:0]  cnt;
    logic [ARGI_W-1:0]  ai;
    logic [19:0]        prod;
    logic               sat;
    logic [3:0]         digit;
    logic               printable;

    always_comb
    begin
        mode_next = mode_reg;
        argc_next = argc_reg;
        rres_next = rres_reg;
        cres_next = cres_reg;
        for (int i = 0; i < MAX_ARGS; i++)
        begin
            arg_next[i] = arg_reg[i];
        end
        push_op        = '0;
        push_op.kind   = OP_NOP;
        push_op.chr    = char_byte;
        push_op.idx    = ADDR_W'(cell_index);
        push_op.idx_ok = (32'(cell_index) < 32'(CELLS));
        push_op.row    = (arg_reg[0] == '0) ? '0 :
                         (rres_reg == '0) ? ROW_W'(ROWS - 1) : rres_reg - 1'b1;
        push_op.col    = cres_reg;

        cnt       = (argc_reg == '0) ? ARGC_W'(1) : argc_reg;
        ai        = ARGI_W'(cnt - 1'b1);
        digit     = 4'(char_byte - CH_ZERO);
        prod      = 20'(arg_reg[ai]) * 20'd10 + 20'(digit);
        sat       = (prod > 20'(ARG_MAX));
        printable = (char_byte >= CH_PR_LO) && (char_byte <= CH_PR_HI);

        if (opcode == OPC_READ)
        begin
            push_op.kind = OP_READ;
        end
        else
        begin
            unique case (mode_reg)
                M_NORMAL:
                begin
                    if (char_byte == CH_ESC)
                    begin
                        mode_next = M_ESCAPE;
                        argc_next = '0;
                        rres_next = '0;
                        cres_next = '0;
                        for (int i = 0; i < MAX_ARGS; i++)
                        begin
                            arg_next[i] = '0;
                        end
                    end
                    else
                    begin
                        push_op.kind = OP_RAW;
                    end
                end
                M_ESCAPE:
                begin
                    if (char_byte == CH_LBRK)
                    begin
                        mode_next = M_BRACKET;
                    end
                    else
                    begin
                        mode_next    = M_NORMAL;
                        push_op.kind = OP_ESC_RAW;
                    end
                end
                M_BRACKET:
                begin
                    if (!printable)
                    begin
                        mode_next = M_NORMAL;
                    end
                    else if (char_byte >= CH_ZERO && char_byte <= CH_NINE)
                    begin
                        argc_next = cnt;
                        if (32'(cnt) <= 32'(MAX_ARGS))
                        begin
                            arg_next[ai] = sat ? ARG_W'(ARG_MAX) : prod[ARG_W-1:0];
                            if (ai == ARGI_W'(0))
                            begin
                                rres_next = sat ? ROW_W'(SAT_ROW)
                                          : mod_rows(12'(rres_reg) * 12'd10 + 12'(digit));
                            end
                            if (ai == ARGI_W'(1))
                            begin
                                cres_next = sat ? COL_W'(SAT_COL)
                                          : mod_cols(12'(cres_reg) * 12'd10 + 12'(digit));
                            end
                        end
                    end
                    else if (char_byte == CH_SEMI)
                    begin
                        if (32'(argc_reg) <= 32'(MAX_ARGS))
                        begin
                            argc_next = argc_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        mode_next = M_NORMAL;
                        if (char_byte == CH_HOME)
                        begin
                            push_op.kind = OP_HOME;
                        end
                        else if (char_byte == CH_CLR)
                        begin
                            push_op.kind = OP_WIPE_ALL;
                        end
                        else if (char_byte == CH_ERASE && argc_reg == ARGC_W'(1))
                        begin
                            push_op.kind = OP_WIPE_LINE;
                        end
                        else if (char_byte == CH_GOTO && argc_reg == ARGC_W'(2))
                        begin
                            push_op.kind = OP_GOTO;
                        end
                    end
                end
                default:
                begin
                    mode_next = M_NORMAL;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_NORMAL;
            argc_reg <= '0;
            rres_reg <= '0;
            cres_reg <= '0;
            for (int i = 0; i < MAX_ARGS; i++)
            begin
                arg_reg[i] <= '0;
            end
        end
        else if (take)
        begin
            mode_reg <= mode_next;
            argc_reg <= argc_next;
            rres_reg <= rres_next;
            cres_reg <= cres_next;
            for (int i = 0; i < MAX_ARGS; i++)
            begin
                arg_reg[i] <= arg_next[i];
            end
        end
    end

    assign push = take;

endmodule

// ----- design/tce_back.sv -----
module tce_back
    import tce_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [ATTR_W-1:0]  attr,
    input  op_t                head_op,
    input  logic               empty,
    output logic               pop,
    output logic               clearing,
    output logic               done,
    output logic [IDX_W-1:0]   cursor_position,
    output logic [WORD_W-1:0]  cell_word
);

    back_state_t        state_reg, state_next;
    op_t                op_reg, op_next;
    logic [LIN_W-1:0]   ptr_reg, ptr_next;
    logic [LIN_W-1:0]   end_reg, end_next;
    logic               pend_reg, pend_next;
    logic [ADDR_W-1:0]  wa_reg, wa_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ADDR_W-1:0]  lin_reg, lin_next;
    logic               esc_reg, esc_next;
    logic               follow_reg, follow_next;
    logic [WORD_W-1:0]  word_reg, word_next;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [WORD_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [WORD_W-1:0]  ram_rdata;

    logic [CHR_W-1:0]   pb;
    logic [ROW_W-1:0]   p_row;
    logic [COL_W-1:0]   p_col;
    logic [LIN_W-1:0]   p_lin;
    logic               p_we;
    logic               p_scroll;
    logic [LIN_W-1:0]   tab_sum;
    logic [COL_W:0]     tab_col;
    logic               stream_busy;

    tce_ram #(.WIDTH(WORD_W), .DEPTH(CELLS)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // one raw byte against the cursor
    always_comb
    begin
        pb      = esc_reg ? CH_ESC : op_reg.chr;
        p_row   = row_reg;
        p_col   = col_reg;
        p_lin   = LIN_W'(lin_reg);
        p_we    = 1'b0;
        tab_sum = LIN_W'(lin_reg) + LIN_W'(8);
        tab_sum = {tab_sum[LIN_W-1:3], 3'b000};
        tab_col = (COL_W+1)'(col_reg) + (COL_W+1)'(tab_sum - LIN_W'(lin_reg));
        case (pb)
            CH_CR:
            begin
                p_col = '0;
                p_lin = LIN_W'(lin_reg) - LIN_W'(col_reg);
            end
            CH_LF:
            begin
                p_row = row_reg + 1'b1;
                p_col = '0;
                p_lin = LIN_W'(lin_reg) - LIN_W'(col_reg) + LIN_W'(COLUMNS);
            end
            CH_BS:
            begin
                if (lin_reg != '0)
                begin
                    p_lin = LIN_W'(lin_reg) - 1'b1;
                    if (col_reg == '0)
                    begin
                        p_col = COL_W'(COLUMNS - 1);
                        p_row = row_reg - 1'b1;
                    end
                    else
                    begin
                        p_col = col_reg - 1'b1;
                    end
                end
            end
            CH_TAB:
            begin
                p_lin = tab_sum;
                if (tab_col >= (COL_W+1)'(COLUMNS))
                begin
                    p_col = COL_W'(tab_col - (COL_W+1)'(COLUMNS));
                    p_row = row_reg + 1'b1;
                end
                else
                begin
                    p_col = COL_W'(tab_col);
                end
            end
            default:
            begin
                p_we  = 1'b1;
                p_lin = LIN_W'(lin_reg) + 1'b1;
                if (col_reg == COL_W'(COLUMNS - 1))
                begin
                    p_col = '0;
                    p_row = row_reg + 1'b1;
                end
                else
                begin
                    p_col = col_reg + 1'b1;
                end
            end
        endcase
        p_scroll = (p_lin >= LIN_W'(CELLS));
    end

    assign stream_busy = (ptr_reg < end_reg) || pend_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_CLEAR:
            begin
                if (ptr_reg == LIN_W'(CELLS - 1))
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (!empty)
                begin
                    unique case (head_op.kind)
                        OP_READ:                   state_next = B_READ;
                        OP_RAW, OP_ESC_RAW:        state_next = B_PUT;
                        OP_WIPE_ALL, OP_WIPE_LINE: state_next = B_WIPE;
                        default:                   state_next = B_EMIT;
                    endcase
                end
            end
            B_READ:
            begin
                state_next = B_EMIT;
            end
            B_PUT:
            begin
                if (p_scroll)
                begin
                    state_next = B_SCROLL;
                end
                else if (esc_reg)
                begin
                    state_next = B_PUT;
                end
                else
                begin
                    state_next = B_EMIT;
                end
            end
            B_SCROLL:
            begin
                if (!stream_busy)
                begin
                    state_next = B_FILL;
                end
            end
            B_FILL:
            begin
                if (ptr_reg == LIN_W'(CELLS - 1))
                begin
                    state_next = follow_reg ? B_PUT : B_EMIT;
                end
            end
            B_WIPE:
            begin
                if (!stream_busy)
                begin
                    state_next = B_EMIT;
                end
            end
            B_EMIT:
            begin
                state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        op_next     = op_reg;
        ptr_next    = ptr_reg;
        end_next    = end_reg;
        pend_next   = 1'b0;
        wa_next     = wa_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        lin_next    = lin_reg;
        esc_next    = esc_reg;
        follow_next = follow_reg;
        word_next   = word_reg;
        pop         = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = ADDR_W'(ptr_reg);
        ram_wdata   = '0;
        ram_raddr   = ADDR_W'(ptr_reg);
        unique case (state_reg)
            B_CLEAR:
            begin
                ram_we   = 1'b1;
                ptr_next = ptr_reg + 1'b1;
            end
            B_IDLE:
            begin
                ram_raddr = head_op.idx;
                if (!empty)
                begin
                    pop         = 1'b1;
                    op_next     = head_op;
                    esc_next    = (head_op.kind == OP_ESC_RAW);
                    follow_next = 1'b0;
                    word_next   = '0;
                    ptr_next    = (head_op.kind == OP_WIPE_ALL) ? '0
                                : LIN_W'(lin_reg) - LIN_W'(col_reg);
                    end_next    = (head_op.kind == OP_WIPE_ALL) ? LIN_W'(CELLS)
                                : LIN_W'(lin_reg) - LIN_W'(col_reg) + LIN_W'(COLUMNS);
                    if (head_op.kind == OP_HOME)
                    begin
                        row_next = '0;
                        col_next = '0;
                        lin_next = '0;
                    end
                    else if (head_op.kind == OP_GOTO)
                    begin
                        row_next = head_op.row;
                        col_next = head_op.col;
                        lin_next = ADDR_W'(LIN_W'(head_op.row) * LIN_W'(COLUMNS)
                                   + LIN_W'(head_op.col));
                    end
                end
            end
            B_READ:
            begin
                word_next = op_reg.idx_ok ? ram_rdata : '0;
            end
            B_PUT:
            begin
                ram_we      = p_we;
                ram_waddr   = lin_reg;
                ram_wdata   = {attr, pb};
                esc_next    = 1'b0;
                follow_next = esc_reg;
                if (p_scroll)
                begin
                    row_next = ROW_W'(ROWS - 1);
                    col_next = '0;
                    lin_next = ADDR_W'(CELLS - COLUMNS);
                    ptr_next = '0;
                    end_next = LIN_W'(CELLS - COLUMNS);
                end
                else
                begin
                    row_next = p_row;
                    col_next = p_col;
                    lin_next = ADDR_W'(p_lin);
                end
            end
            B_SCROLL:
            begin
                // read one line down, write the word read last cycle
                ram_raddr = ADDR_W'(ptr_reg + LIN_W'(COLUMNS));
                ram_we    = pend_reg;
                ram_waddr = wa_reg;
                ram_wdata = ram_rdata;
                if (ptr_reg < end_reg)
                begin
                    pend_next = 1'b1;
                    wa_next   = ADDR_W'(ptr_reg);
                    ptr_next  = ptr_reg + 1'b1;
                end
                else
                begin
                    ptr_next = LIN_W'(CELLS - COLUMNS);
                end
            end
            B_FILL:
            begin
                ram_we    = 1'b1;
                ram_wdata = BLANK_CELL;
                ptr_next  = ptr_reg + 1'b1;
            end
            B_WIPE:
            begin
                ram_we    = pend_reg;
                ram_waddr = wa_reg;
                ram_wdata = ram_rdata & ATTR_MASK;
                if (ptr_reg < end_reg)
                begin
                    pend_next = 1'b1;
                    wa_next   = ADDR_W'(ptr_reg);
                    ptr_next  = ptr_reg + 1'b1;
                end
            end
            B_EMIT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_CLEAR;
            ptr_reg    <= '0;
            end_reg    <= '0;
            pend_reg   <= 1'b0;
            row_reg    <= '0;
            col_reg    <= '0;
            lin_reg    <= '0;
            esc_reg    <= 1'b0;
            follow_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ptr_reg    <= ptr_next;
            end_reg    <= end_next;
            pend_reg   <= pend_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
            lin_reg    <= lin_next;
            esc_reg    <= esc_next;
            follow_reg <= follow_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        wa_reg   <= wa_next;
        word_reg <= word_next;
    end

    assign clearing        = (state_reg == B_CLEAR);
    assign done            = (state_reg == B_EMIT);
    assign cursor_position = IDX_W'(lin_reg);
    assign cell_word       = word_reg;

endmodule
